// ===== hdl/avt_pkg.sv =====
package avt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_PAIRS = 8;
    localparam int NUM_LANES = 4;
    localparam int COMP_W    = 32;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;
    localparam int REG_IDX_W = 3;
    localparam int REG_LSB   = 3;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [PDATA_W-1:0]       pair_t;
    typedef logic [1:0]               mode_t;

    localparam mode_t MODE_2D = 2'd0;
    localparam mode_t MODE_3D = 2'd1;
    localparam mode_t MODE_4D = 2'd2;

    localparam comp_t ONE_Q   = comp_t'(1) << FRAC_BITS;
    localparam comp_t SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    localparam pair_t ONE_LO = pair_t'(1) << FRAC_BITS;
    localparam pair_t ONE_HI = ONE_LO << COMP_W;

    // identity matrix: diagonal elements 0, 5, 10 and 15
    localparam pair_t COEF_RESET [NUM_PAIRS] =
        '{ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI};

    typedef struct packed {
        logic prod;
        logic acc;
        logic res;
    } stage_en_t;

endpackage

// ===== hdl/avt_cfg.sv =====
module avt_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [avt_pkg::PADDR_W-1:0]  paddr,
    input  logic [avt_pkg::PDATA_W-1:0]  pwdata,
    output logic [avt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output avt_pkg::pair_t               coef [avt_pkg::NUM_PAIRS]
);

    avt_pkg::pair_t                   coef_reg [avt_pkg::NUM_PAIRS];
    logic [avt_pkg::REG_IDX_W-1:0]    idx;
    logic                             wr_en;

    assign idx    = paddr[avt_pkg::REG_LSB +: avt_pkg::REG_IDX_W];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = coef_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= avt_pkg::COEF_RESET;
        end
        else if (wr_en)
        begin
            coef_reg[idx] <= pwdata;
        end
    end

    assign coef = coef_reg;

endmodule

// ===== hdl/avt_lane.sv =====
module avt_lane (
    input  logic                  clk,
    input  avt_pkg::stage_en_t    en,
    input  avt_pkg::comp_t        coef [avt_pkg::NUM_LANES],
    input  avt_pkg::comp_t        vec  [avt_pkg::NUM_LANES],
    output avt_pkg::comp_t        result,
    output logic                  sat
);

    localparam int HI_LSB = avt_pkg::COMP_W - 1 + avt_pkg::FRAC_BITS;

    logic signed [avt_pkg::PROD_W-1:0] prod_reg [avt_pkg::NUM_LANES];
    logic signed [avt_pkg::PAIR_W-1:0] pair_reg [2];
    logic signed [avt_pkg::PAIR_W-1:0] pair_next [2];
    logic signed [avt_pkg::SUM_W-1:0]  sum;
    logic [avt_pkg::SUM_W-1-HI_LSB:0]  hi;
    logic                              fits;
    avt_pkg::comp_t                    result_reg, result_next;
    logic                              sat_reg, sat_next;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            for (int c = 0; c < avt_pkg::NUM_LANES; c++)
            begin
                prod_reg[c] <= coef[c] * vec[c];
            end
        end
    end

    always_comb
    begin
        pair_next[0] = {prod_reg[0][avt_pkg::PROD_W-1], prod_reg[0]}
                     + {prod_reg[1][avt_pkg::PROD_W-1], prod_reg[1]};
        pair_next[1] = {prod_reg[2][avt_pkg::PROD_W-1], prod_reg[2]}
                     + {prod_reg[3][avt_pkg::PROD_W-1], prod_reg[3]};
    end

    always_ff @(posedge clk)
    begin
        if (en.acc)
        begin
            pair_reg <= pair_next;
        end
    end

    // exact sum, floor shift by the fraction width, clamp to 32 bits
    always_comb
    begin
        sum  = {pair_reg[0][avt_pkg::PAIR_W-1], pair_reg[0]}
             + {pair_reg[1][avt_pkg::PAIR_W-1], pair_reg[1]};
        hi   = sum[avt_pkg::SUM_W-1:HI_LSB];
        fits = (&hi) || !(|hi);
        sat_next = !fits;
        if (fits)
        begin
            result_next = sum[HI_LSB:avt_pkg::FRAC_BITS];
        end
        else if (sum[avt_pkg::SUM_W-1])
        begin
            result_next = avt_pkg::SAT_MIN;
        end
        else
        begin
            result_next = avt_pkg::SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.res)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

// ===== hdl/avt_merge.sv =====
module avt_merge (
    input  logic                 clk,
    input  logic                 en,
    input  avt_pkg::mode_t       kind,
    input  avt_pkg::comp_t       lane_res [avt_pkg::NUM_LANES],
    input  logic                 lane_sat [avt_pkg::NUM_LANES],
    output avt_pkg::comp_t       out_x,
    output avt_pkg::comp_t       out_y,
    output avt_pkg::comp_t       out_z,
    output avt_pkg::comp_t       out_w,
    output logic                 clipped
);

    logic           use_z, use_w;
    avt_pkg::comp_t x_reg, y_reg, z_reg, w_reg;
    avt_pkg::comp_t z_next, w_next;
    logic           clipped_reg, clipped_next;

    always_comb
    begin
        use_z = (kind != avt_pkg::MODE_2D);
        use_w = (kind != avt_pkg::MODE_2D) && (kind != avt_pkg::MODE_3D);
        // drop components the mode does not produce
        z_next = use_z ? lane_res[2] : '0;
        w_next = use_w ? lane_res[3] : '0;
        clipped_next = lane_sat[0] || lane_sat[1]
                    || (use_z && lane_sat[2]) || (use_w && lane_sat[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= lane_res[0];
            y_reg       <= lane_res[1];
            z_reg       <= z_next;
            w_reg       <= w_next;
            clipped_reg <= clipped_next;
        end
    end

    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;
    assign out_w   = w_reg;
    assign clipped = clipped_reg;

endmodule

// ===== hdl/affine_vertex_transform_unit.sv =====
// Channel   Dir   Payload
// s_*       in    tdata {in_w, in_z, in_y, in_x}, tuser kind
// m_*       out   tdata {out_w, out_z, out_y, out_x}, tuser clipped
// apb       in    coef_pair_0..7 at byte address 8*i, 64-bit data
//
// One item per cycle sustained while m_tready is high.
// Four lanes, one per result row, each with four 32x32 multipliers; the
// multiply, pair add, final add/clamp and output register set the depth.
// Reset clears the valid bits and loads the identity matrix.
// A stalled output holds; stages behind it fill bubbles before s_tready drops.
module affine_vertex_transform_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [127:0]                 s_tdata,  // in_x, in_y, in_z, in_w
    input  logic [1:0]                   s_tuser,  // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [127:0]                 m_tdata,  // out_x, out_y, out_z, out_w
    output logic [0:0]                   m_tuser,  // clipped
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [avt_pkg::PADDR_W-1:0]  paddr,
    input  logic [avt_pkg::PDATA_W-1:0]  pwdata,
    output logic [avt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int W  = avt_pkg::COMP_W;
    localparam int NL = avt_pkg::NUM_LANES;

    avt_pkg::pair_t     coef [avt_pkg::NUM_PAIRS];
    avt_pkg::comp_t     vec [NL];
    avt_pkg::comp_t     lane_coef [NL][NL];
    avt_pkg::comp_t     lane_res [NL];
    logic               lane_sat [NL];
    avt_pkg::stage_en_t en;
    avt_pkg::mode_t     kind_in;
    avt_pkg::mode_t     kind_p_reg, kind_a_reg, kind_r_reg;
    avt_pkg::comp_t     out_x, out_y, out_z, out_w;
    logic               clipped;

    logic p_v_reg, p_v_next, a_v_reg, a_v_next;
    logic r_v_reg, r_v_next, o_v_reg, o_v_next;
    logic p_adv, a_adv, r_adv, o_adv;

    avt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // form the vector the mode implies
    always_comb
    begin
        kind_in = s_tuser;
        vec[0]  = s_tdata[0*W +: W];
        vec[1]  = s_tdata[1*W +: W];
        vec[2]  = (kind_in == avt_pkg::MODE_2D) ? '0 : s_tdata[2*W +: W];
        vec[3]  = ((kind_in == avt_pkg::MODE_2D) || (kind_in == avt_pkg::MODE_3D))
                ? avt_pkg::ONE_Q : s_tdata[3*W +: W];
    end

    always_comb
    begin
        o_adv    = !o_v_reg || m_tready;
        r_adv    = !r_v_reg || o_adv;
        a_adv    = !a_v_reg || r_adv;
        p_adv    = !p_v_reg || a_adv;
        p_v_next = p_adv ? s_tvalid : p_v_reg;
        a_v_next = a_adv ? p_v_reg  : a_v_reg;
        r_v_next = r_adv ? a_v_reg  : r_v_reg;
        o_v_next = o_adv ? r_v_reg  : o_v_reg;
        en.prod  = p_adv;
        en.acc   = a_adv;
        en.res   = r_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            a_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= p_v_next;
            a_v_reg <= a_v_next;
            r_v_reg <= r_v_next;
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            kind_p_reg <= kind_in;
        end
        if (a_adv)
        begin
            kind_a_reg <= kind_p_reg;
        end
        if (r_adv)
        begin
            kind_r_reg <= kind_a_reg;
        end
    end

    // lane r takes elements r, 4+r, 8+r, 12+r of the column-major matrix
    for (genvar r = 0; r < NL; r++)
    begin : g_lane
        for (genvar c = 0; c < NL; c++)
        begin : g_coef
            assign lane_coef[r][c] =
                coef[(NL*c + r) / 2][((NL*c + r) % 2) * W +: W];
        end

        avt_lane u_lane (
            .clk    (clk),
            .en     (en),
            .coef   (lane_coef[r]),
            .vec    (vec),
            .result (lane_res[r]),
            .sat    (lane_sat[r])
        );
    end

    avt_merge u_merge (
        .clk      (clk),
        .en       (o_adv),
        .kind     (kind_r_reg),
        .lane_res (lane_res),
        .lane_sat (lane_sat),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z),
        .out_w    (out_w),
        .clipped  (clipped)
    );

    assign s_tready   = p_adv;
    assign m_tvalid   = o_v_reg;
    assign m_tdata    = {out_w, out_z, out_y, out_x};
    assign m_tuser[0] = clipped;

endmodule

// ===== hdl/avt_chk.sv =====
module avt_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input backpressure only comes from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output empty");

    // clipped requires a clamped component
    a_clip_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[31:0]   == MAXV) || (m_tdata[31:0]   == MINV) ||
            (m_tdata[63:32]  == MAXV) || (m_tdata[63:32]  == MINV) ||
            (m_tdata[95:64]  == MAXV) || (m_tdata[95:64]  == MINV) ||
            (m_tdata[127:96] == MAXV) || (m_tdata[127:96] == MINV))
        else $error("clipped set without a clamped component");

    // an offered item is taken whenever the output side is ready
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && m_tready |-> s_tready)
        else $error("input stalled with output ready");

endmodule

bind affine_vertex_transform_unit avt_chk u_avt_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/affine_vertex_transform_unit_tb.sv =====
`timescale 1ns / 100ps

module affine_vertex_transform_unit_tb;

    localparam avt_pkg::mode_t MODE_RSVD = 2'd3;   // undefined code, acts as the full product
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    PHASE_ITEMS = 220;
    localparam int    HOLD_CYCLES = 300;
    localparam int    IDLE_PCT    = 8;
    localparam int    DRAIN_WAIT  = 8;

    localparam logic signed [avt_pkg::SUM_W-1:0] CLAMP_HI = 66'sd2147483647;
    localparam logic signed [avt_pkg::SUM_W-1:0] CLAMP_LO = -66'sd2147483648;

    typedef enum int {COEF_FULL, COEF_SMALL, COEF_MIXED} coef_style_t;

    typedef struct {
        avt_pkg::mode_t kind;
        avt_pkg::comp_t x;
        avt_pkg::comp_t y;
        avt_pkg::comp_t z;
        avt_pkg::comp_t w;
    } vec_item_t;

    typedef struct {
        avt_pkg::comp_t x;
        avt_pkg::comp_t y;
        avt_pkg::comp_t z;
        avt_pkg::comp_t w;
        logic           clip;
    } vec_result_t;

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [127:0]   s_tdata  = '0;  // in_x, in_y, in_z, in_w
    logic [1:0]     s_tuser  = '0;  // kind
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [127:0]   m_tdata;        // out_x, out_y, out_z, out_w
    logic [0:0]     m_tuser;        // clipped
    logic           psel     = 1'b0;
    logic           penable  = 1'b0;
    logic           pwrite   = 1'b0;
    logic [avt_pkg::PADDR_W-1:0] paddr  = '0;
    logic [avt_pkg::PDATA_W-1:0] pwdata = '0;
    logic [avt_pkg::PDATA_W-1:0] prdata;
    logic           pready;

    avt_pkg::pair_t coef_model [avt_pkg::NUM_PAIRS];
    vec_item_t     pending_vecs [$];
    vec_result_t   expected_results [$];
    vec_item_t     driven_vec;
    vec_result_t   oldest_result;
    logic          steady    = 1'b0;
    int            errors    = 0;
    int            cycles    = 0;
    int            hold_left = 0;
    int            holds_done = 0;

    affine_vertex_transform_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Row r is sum over columns c of element (4c + r) times v[c], exact,
    // then shifted toward minus infinity and clamped to 32 bits.
    function automatic vec_result_t transform_vec(vec_item_t it);
        avt_pkg::comp_t                     v [avt_pkg::NUM_LANES];
        avt_pkg::comp_t                     outc [avt_pkg::NUM_LANES];
        avt_pkg::comp_t                     elem;
        avt_pkg::pair_t                     pr;
        logic signed [avt_pkg::PROD_W-1:0]  a64;
        logic signed [avt_pkg::PROD_W-1:0]  b64;
        logic signed [avt_pkg::PROD_W-1:0]  prod;
        logic signed [avt_pkg::SUM_W-1:0]   acc;
        logic signed [avt_pkg::SUM_W-1:0]   sh;
        int                                 rows;
        int                                 e;
        logic                               clip;
        vec_result_t                        res;
        v[0] = it.x;
        v[1] = it.y;
        case (it.kind)
            avt_pkg::MODE_2D:
            begin
                v[2] = '0;
                v[3] = avt_pkg::ONE_Q;
                rows = 2;
            end
            avt_pkg::MODE_3D:
            begin
                v[2] = it.z;
                v[3] = avt_pkg::ONE_Q;
                rows = 3;
            end
            default:
            begin
                v[2] = it.z;
                v[3] = it.w;
                rows = 4;
            end
        endcase
        clip = 1'b0;
        for (int r = 0; r < avt_pkg::NUM_LANES; r++)
        begin
            outc[r] = '0;
            if (r < rows)
            begin
                acc = '0;
                for (int c = 0; c < avt_pkg::NUM_LANES; c++)
                begin
                    e = 4 * c + r;
                    pr = coef_model[e / 2];
                    elem = (e % 2 == 1) ? pr[63:32] : pr[31:0];
                    a64 = elem;
                    b64 = v[c];
                    prod = a64 * b64;
                    acc = acc + prod;
                end
                sh = acc >>> avt_pkg::FRAC_BITS;
                if (sh > CLAMP_HI)
                begin
                    sh = CLAMP_HI;
                    clip = 1'b1;
                end
                else if (sh < CLAMP_LO)
                begin
                    sh = CLAMP_LO;
                    clip = 1'b1;
                end
                outc[r] = sh[avt_pkg::COMP_W-1:0];
            end
        end
        res.x = outc[0];
        res.y = outc[1];
        res.z = outc[2];
        res.w = outc[3];
        res.clip = clip;
        return res;
    endfunction

    function automatic void check_field(string name, avt_pkg::comp_t want,
                                        avt_pkg::comp_t got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic avt_pkg::comp_t rand_comp();
        case ($urandom_range(0, 9))
            0:       return avt_pkg::SAT_MAX;
            1:       return avt_pkg::SAT_MIN;
            2, 3, 4: return $urandom;
            default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic avt_pkg::comp_t rand_elem(coef_style_t style);
        case (style)
            COEF_FULL:  return $urandom;
            COEF_SMALL:
            begin
                if ($urandom_range(0, 5) == 0)
                    return ($urandom_range(0, 1) == 1) ? avt_pkg::ONE_Q : '0;
                return int'($urandom_range(0, 1 << 19)) - (1 << 18);
            end
            default:    return rand_comp();
        endcase
    endfunction

    function automatic void push_vec(avt_pkg::mode_t kind, avt_pkg::comp_t x,
                                     avt_pkg::comp_t y, avt_pkg::comp_t z,
                                     avt_pkg::comp_t w);
        vec_item_t it;
        it.kind = kind;
        it.x = x;
        it.y = y;
        it.z = z;
        it.w = w;
        pending_vecs.push_back(it);
    endfunction

    task automatic write_coef(input int idx, input avt_pkg::pair_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= avt_pkg::PADDR_W'(idx << avt_pkg::REG_LSB);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        // the register takes the value at this edge
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        coef_model[idx] = val;
    endtask

    task automatic program_uniform(input avt_pkg::comp_t elem);
        for (int i = 0; i < avt_pkg::NUM_PAIRS; i++)
            write_coef(i, {elem, elem});
    endtask

    task automatic program_random(input coef_style_t style);
        avt_pkg::comp_t lo;
        avt_pkg::comp_t hi;
        for (int i = 0; i < avt_pkg::NUM_PAIRS; i++)
        begin
            lo = rand_elem(style);
            hi = rand_elem(style);
            write_coef(i, {hi, lo});
        end
    endtask

    task automatic wait_drain();
        while (pending_vecs.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    // driver: offer the next pending item, predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(transform_vec(driven_vec));
            if (!s_tvalid || s_tready)
            begin
                if (pending_vecs.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    driven_vec = pending_vecs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {driven_vec.w, driven_vec.z, driven_vec.y, driven_vec.x};
                    s_tuser  <= driven_vec.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each item against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: unexpected item, expected none actual %h clipped %b",
                             $time, m_tdata, m_tuser[0]);
                    errors++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    check_field("out_x", oldest_result.x, m_tdata[31:0]);
                    check_field("out_y", oldest_result.y, m_tdata[63:32]);
                    check_field("out_z", oldest_result.z, m_tdata[95:64]);
                    check_field("out_w", oldest_result.w, m_tdata[127:96]);
                    check_field("clipped", avt_pkg::comp_t'(oldest_result.clip),
                                avt_pkg::comp_t'(m_tuser[0]));
                end
            end
            // hold off long enough to back the pipeline up to the input
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_done < 2 && pending_vecs.size() > 200)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < avt_pkg::NUM_PAIRS; i++)
            coef_model[i] = avt_pkg::COEF_RESET[i];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // identity after reset: exact pass-through, ignored inputs nonzero
        push_vec(avt_pkg::MODE_2D, '0, '0, '0, '0);
        push_vec(avt_pkg::MODE_2D, avt_pkg::SAT_MAX, avt_pkg::SAT_MIN,
                 avt_pkg::SAT_MAX, avt_pkg::SAT_MAX);
        push_vec(avt_pkg::MODE_3D, avt_pkg::SAT_MAX, avt_pkg::SAT_MIN,
                 avt_pkg::SAT_MAX, avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_4D, avt_pkg::SAT_MAX, avt_pkg::SAT_MAX,
                 avt_pkg::SAT_MAX, avt_pkg::SAT_MAX);
        push_vec(avt_pkg::MODE_4D, avt_pkg::SAT_MIN, avt_pkg::SAT_MIN,
                 avt_pkg::SAT_MIN, avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_4D, 32'sd1, -32'sd1, avt_pkg::ONE_Q, -avt_pkg::ONE_Q);
        push_vec(MODE_RSVD, avt_pkg::SAT_MIN, avt_pkg::SAT_MAX,
                 avt_pkg::SAT_MIN, avt_pkg::SAT_MAX);
        push_vec(avt_pkg::MODE_3D, -32'sd1, 32'sd1, -32'sd1, '0);
        wait_drain();

        // largest coefficients: saturate both ways
        program_uniform(avt_pkg::SAT_MAX);
        push_vec(avt_pkg::MODE_2D, avt_pkg::SAT_MAX, avt_pkg::SAT_MAX,
                 avt_pkg::SAT_MIN, avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_4D, avt_pkg::SAT_MIN, avt_pkg::SAT_MIN,
                 avt_pkg::SAT_MIN, avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_3D, avt_pkg::SAT_MAX, avt_pkg::SAT_MIN,
                 32'sd1, avt_pkg::SAT_MAX);
        push_vec(MODE_RSVD, '0, '0, '0, 32'sd1);
        push_vec(avt_pkg::MODE_4D, 32'sd1, -32'sd1, 32'sd1, -32'sd1);
        wait_drain();

        // most negative coefficients
        program_uniform(avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_4D, avt_pkg::SAT_MIN, avt_pkg::SAT_MIN,
                 avt_pkg::SAT_MIN, avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_4D, avt_pkg::SAT_MAX, avt_pkg::SAT_MAX,
                 avt_pkg::SAT_MAX, avt_pkg::SAT_MAX);
        push_vec(avt_pkg::MODE_2D, '0, '0, avt_pkg::SAT_MAX, avt_pkg::SAT_MAX);
        push_vec(avt_pkg::MODE_3D, -32'sd1, 32'sd1, '0, '0);
        wait_drain();

        program_uniform('0);
        push_vec(avt_pkg::MODE_4D, avt_pkg::SAT_MAX, avt_pkg::SAT_MIN,
                 avt_pkg::SAT_MAX, avt_pkg::SAT_MIN);
        push_vec(avt_pkg::MODE_2D, avt_pkg::SAT_MIN, avt_pkg::SAT_MAX, '0, '0);
        wait_drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph % 3)
                0:       program_random(COEF_SMALL);
                1:       program_random(COEF_MIXED);
                default: program_random(COEF_FULL);
            endcase
            steady <= (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_vec(avt_pkg::mode_t'($urandom_range(0, 3)), rand_comp(), rand_comp(),
                         rand_comp(), rand_comp());
            wait_drain();
        end

        steady <= 1'b0;
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
